@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle (cons may start with ##N).
`define AFF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("aff assertion failed");

// Whenever ante holds, cons must hold in the next cycle.
`define AFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aff assertion failed");

`endif

@@ rtl/aff_pkg.sv @@
// ----------------------------------------------------------------------------
// aff_pkg
// Types, coefficient tables and constants of the atomic form factor pipeline.
// ----------------------------------------------------------------------------
package aff_pkg;

  localparam int Q_FRAC_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF  = 16;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam int Q_W   = 21;
  localparam int Z_W   = 7;
  localparam int OUT_W = 24;
  localparam int A_W   = 21;
  localparam int B_W   = 23;
  localparam int C_W   = 21;

  // 1/(16 pi^2), log2(e) in Q24 and ln(2) in Q32.
  localparam logic [16:0] INV16PI2_Q24 = 17'd106243;
  localparam logic [24:0] LOG2E_Q24    = 25'd24204406;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;

  localparam logic [Z_W-1:0] ZNUM_H  = 7'd1;
  localparam logic [Z_W-1:0] ZNUM_O  = 7'd8;
  localparam logic [Z_W-1:0] ZNUM_FE = 7'd26;
  localparam logic [Z_W-1:0] ZNUM_AU = 7'd79;

  typedef enum logic [2:0] {
    SET_H,
    SET_O,
    SET_FE,
    SET_AU,
    SET_N
  } coef_sel_t;

  typedef struct packed {
    logic [Q_W-1:0] q_magnitude;
    logic [Z_W-1:0] atomic_number;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] scattering_factor;
    logic                    used_fallback;
  } out_item_t;

  typedef struct packed {
    coef_sel_t sel;
    logic      fallback;
  } item_meta_t;

  function automatic logic [A_W-1:0] coef_a(coef_sel_t sel, logic [1:0] i);
    logic [3:0][A_W-1:0] row;
    unique case (sel)
      SET_H:   row = {21'd2675, 21'd9188, 21'd21162, 21'd32309};
      SET_O:   row = {21'd56820, 21'd101338, 21'd149868, 21'd199786};
      SET_FE:  row = {21'd151028, 21'd230831, 21'd482168, 21'd771326};
      SET_AU:  row = {21'd384041, 21'd1674982, 21'd1218399, 21'd1106372};
      default: row = {21'd76435, 21'd131891, 21'd205272, 21'd800365};
    endcase
    return row[i];
  endfunction

  function automatic logic [B_W-1:0] coef_b(coef_sel_t sel, logic [1:0] i);
    logic [3:0][B_W-1:0] row;
    unique case (sel)
      SET_H:   row = {23'd3787961, 23'd205938, 23'd1712174, 23'd688842};
      SET_O:   row = {23'd2156718, 23'd21227, 23'd373627, 23'd870128};
      SET_FE:  row = {23'd5038440, 23'd1006207, 23'd20133, 23'd312023};
      SET_AU:  row = {23'd2385222, 23'd97164, 23'd565025, 23'd30219};
      default: row = {23'd38181, 23'd1900380, 23'd648367, 23'd374};
    endcase
    return row[i];
  endfunction

  function automatic logic signed [C_W-1:0] coef_c(coef_sel_t sel);
    logic signed [C_W-1:0] c;
    unique case (sel)
      SET_H:   c = 21'sd199;
      SET_O:   c = 21'sd16436;
      SET_FE:  c = 21'sd67954;
      SET_AU:  c = 21'sd790744;
      default: c = -21'sd755565;
    endcase
    return c;
  endfunction

  // Restoring long division, used only while the constant table is elaborated.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k of the 2^(-k/2^eb) table in Q30, evaluated at elaboration only.
  function automatic logic [30:0] pow2_entry(int unsigned k, int unsigned eb);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    z    = (64'(k) * LN2_Q32) >> eb;
    term = 64'd1 << 32;
    sum  = term;
    for (int j = 1; j <= 20; j++) begin
      term = udiv64((term * z) >> 32, 64'(j));
      sum  = sum + term;
    end
    return 31'(udiv64(64'd1 << 62, sum));
  endfunction

endpackage

@@ rtl/atomic_form_factor_unit.sv @@
// ----------------------------------------------------------------------------
// atomic_form_factor_unit
// Four-Gaussian atomic form factor f(q, Z) in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers in at a rising edge with start high and busy low. busy
//   is always low, so a new item may enter in every cycle.
//   in_data carries q_magnitude (unsigned, Q_FRAC_BITS fractional bits) and
//   atomic_number. Elements 1, 8, 26 and 79 have their own coefficients; all
//   others use nitrogen and set used_fallback.
//   Each result appears on out_data for exactly one cycle with out_valid high,
//   in input order. Throughput is one item per cycle; the four Gaussian
//   terms run in parallel lanes.
//   The receiver cannot stall, so the pipeline never holds.
//   Synchronous active-low reset clears all valid bits; items in flight are
//   dropped and no result appears until new items arrive.
//   The exponential uses a 2^EXP_TABLE_BITS+1 entry constant table with
//   linear interpolation; the result saturates to 24 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atomic_form_factor_unit #(
  parameter int Q_FRAC_BITS    = aff_pkg::Q_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS  = aff_pkg::OUT_FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = aff_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  aff_pkg::in_item_t in_data,
  output logic              out_valid,
  output aff_pkg::out_item_t out_data
);

  localparam int LAT    = 11;
  localparam int NMETA  = 10;
  localparam int QSQ_W  = 2 * aff_pkg::Q_W;
  localparam int Q2_SH  = 2 * Q_FRAC_BITS - 16;
  localparam int Q2_W   = QSQ_W - Q2_SH;
  localparam int SF_W   = Q2_W + 1;
  localparam int S_W    = 39;
  localparam int SC_W   = (SF_W > S_W) ? SF_W : S_W;
  localparam int SLO_W  = 20;
  localparam int SHI_W  = S_W - SLO_W;
  localparam int PLO_W  = SLO_W + aff_pkg::B_W;
  localparam int PHI_W  = SHI_W + aff_pkg::B_W;
  localparam int XS_W   = S_W + aff_pkg::B_W + 1;
  localparam int X_W    = 30;
  localparam int YP_W   = X_W + 25;
  localparam int FB     = 24 - EXP_TABLE_BITS;
  localparam int TBL_N  = (1 << EXP_TABLE_BITS) + 1;
  localparam int TI_W   = EXP_TABLE_BITS + 1;
  localparam int T_W    = 31;
  localparam int DP_W   = T_W + FB;
  localparam int TERM_W = aff_pkg::A_W + T_W - 16;
  localparam int ACC_W  = 40;
  localparam int RSH    = 30 - OUT_FRAC_BITS;

  // Anything at or above 2^38 drives every lane's exponent to zero.
  localparam logic [SC_W-1:0] S_CLAMP = SC_W'(64'd1 << 38);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RSH - 1);
  localparam logic signed [ACC_W-1:0] R_MAX = (ACC_W'(1) <<< 23) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] R_MIN = -(ACC_W'(1) <<< 23);

  logic [T_W-1:0] exp_tbl [TBL_N];

  for (genvar k = 0; k < TBL_N; k++) begin : g_tbl
    localparam logic [T_W-1:0] TV = aff_pkg::pow2_entry(k, EXP_TABLE_BITS);
    assign exp_tbl[k] = TV;
  end

  logic [LAT-1:0]      vld_r;
  aff_pkg::item_meta_t meta_r [NMETA];
  aff_pkg::item_meta_t meta_nxt;

  logic [QSQ_W-1:0] qsq_r;
  logic [S_W-1:0]   s_r;
  logic [Q2_W-1:0]  q2;
  logic [Q2_W+16:0] sprod;
  logic [SC_W-1:0]  s_ext;
  logic [S_W-1:0]   s_nxt;

  logic [PLO_W-1:0] plo_r  [4];
  logic [PHI_W-1:0] phi_r  [4];
  logic [X_W-1:0]   x_r    [4];
  logic             zx_r   [4];
  logic [4:0]       n5_r   [4];
  logic [EXP_TABLE_BITS-1:0] idx_r [4];
  logic [FB-1:0]    fr5_r  [4];
  logic             z5_r   [4];
  logic [T_W-1:0]   t0_r   [4];
  logic [T_W-1:0]   d_r    [4];
  logic [FB-1:0]    fr6_r  [4];
  logic [4:0]       n6_r   [4];
  logic             z6_r   [4];
  logic [T_W-1:0]   v_r    [4];
  logic [4:0]       n7_r   [4];
  logic             z7_r   [4];
  logic [T_W-1:0]   e_r    [4];
  logic [TERM_W-1:0] term_r [4];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] c_ext;
  logic signed [ACC_W-1:0] rsh;
  aff_pkg::out_item_t out_r;
  aff_pkg::out_item_t out_nxt;

  logic accept;
  logic in_known;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_known = (in_data.atomic_number == aff_pkg::ZNUM_H)
                 || (in_data.atomic_number == aff_pkg::ZNUM_O)
                 || (in_data.atomic_number == aff_pkg::ZNUM_FE)
                 || (in_data.atomic_number == aff_pkg::ZNUM_AU);

  // Element decode.
  always_comb begin
    meta_nxt.fallback = 1'b0;
    unique case (in_data.atomic_number)
      aff_pkg::ZNUM_H:  meta_nxt.sel = aff_pkg::SET_H;
      aff_pkg::ZNUM_O:  meta_nxt.sel = aff_pkg::SET_O;
      aff_pkg::ZNUM_FE: meta_nxt.sel = aff_pkg::SET_FE;
      aff_pkg::ZNUM_AU: meta_nxt.sel = aff_pkg::SET_AU;
      default: begin
        meta_nxt.sel      = aff_pkg::SET_N;
        meta_nxt.fallback = 1'b1;
      end
    endcase
  end

  // s = q^2 / (16 pi^2) in Q24, clamped.
  always_comb begin
    q2    = Q2_W'(qsq_r >> Q2_SH);
    sprod = (Q2_W + 17)'(q2) * (Q2_W + 17)'(aff_pkg::INV16PI2_Q24);
    s_ext = SC_W'(sprod[Q2_W+16:16]);
    s_nxt = (s_ext > S_CLAMP) ? S_W'(S_CLAMP) : s_ext[S_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_nxt;
    for (int k = 1; k < NMETA; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
    qsq_r <= QSQ_W'(in_data.q_magnitude) * QSQ_W'(in_data.q_magnitude);
    s_r   <= s_nxt;
  end

  // Four exponential lanes.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int B_W_L = aff_pkg::B_W;
    logic [B_W_L-1:0] b_val;
    logic [XS_W-1:0]  xsum;
    logic [YP_W-1:0]  yprod;
    logic [30:0]      y;
    logic [DP_W-1:0]  dprod;
    logic [T_W-1:0]   t1;
    logic [TI_W-1:0]  ti0;
    logic [TI_W-1:0]  ti1;
    logic [aff_pkg::A_W+T_W-1:0] aprod;

    always_comb begin
      b_val = aff_pkg::coef_b(meta_r[1].sel, 2'(i));
      xsum  = (XS_W'(phi_r[i]) << SLO_W) + XS_W'(plo_r[i]);
      yprod = YP_W'(x_r[i]) * YP_W'(aff_pkg::LOG2E_Q24);
      y     = yprod[YP_W-1:24];
      ti0   = TI_W'(idx_r[i]);
      ti1   = ti0 + TI_W'(1);
      t1    = exp_tbl[ti1];
      dprod = DP_W'(d_r[i]) * DP_W'(fr6_r[i]);
      aprod = (aff_pkg::A_W + T_W)'(aff_pkg::coef_a(meta_r[7].sel, 2'(i)))
            * (aff_pkg::A_W + T_W)'(e_r[i]);
    end

    always_ff @(posedge clk) begin
      plo_r[i]  <= PLO_W'(s_r[SLO_W-1:0]) * PLO_W'(b_val);
      phi_r[i]  <= PHI_W'(s_r[S_W-1:SLO_W]) * PHI_W'(b_val);
      x_r[i]    <= xsum[X_W+15:16];
      zx_r[i]   <= (xsum[XS_W-1:X_W+16] != '0);
      n5_r[i]   <= y[28:24];
      idx_r[i]  <= y[23:FB];
      fr5_r[i]  <= y[FB-1:0];
      z5_r[i]   <= zx_r[i] || (y[30:29] != 2'b00);
      t0_r[i]   <= exp_tbl[ti0];
      d_r[i]    <= exp_tbl[ti0] - t1;
      fr6_r[i]  <= fr5_r[i];
      n6_r[i]   <= n5_r[i];
      z6_r[i]   <= z5_r[i];
      v_r[i]    <= t0_r[i] - T_W'(dprod >> FB);
      n7_r[i]   <= n6_r[i];
      z7_r[i]   <= z6_r[i];
      e_r[i]    <= z7_r[i] ? '0 : (v_r[i] >> n7_r[i]);
      term_r[i] <= aprod[aff_pkg::A_W+T_W-1:16];
    end
  end

  // Sum of lanes plus c, then round half up and saturate.
  always_comb begin
    c_ext   = ACC_W'(aff_pkg::coef_c(meta_r[8].sel));
    acc_nxt = (c_ext <<< 14) + $signed(ACC_W'(term_r[0])) + $signed(ACC_W'(term_r[1]))
            + $signed(ACC_W'(term_r[2])) + $signed(ACC_W'(term_r[3]));
    rsh     = (acc_r + RND_HALF) >>> RSH;
    out_nxt.used_fallback = meta_r[9].fallback;
    if (rsh > R_MAX) begin
      out_nxt.scattering_factor = R_MAX[aff_pkg::OUT_W-1:0];
    end else if (rsh < R_MIN) begin
      out_nxt.scattering_factor = R_MIN[aff_pkg::OUT_W-1:0];
    end else begin
      out_nxt.scattering_factor = rsh[aff_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  `AFF_ASSERT_IMPL(a_latency, accept, ##LAT out_valid)
  `AFF_ASSERT_IMPL(a_no_orphan, out_valid, $past(accept, LAT))
  `AFF_ASSERT_IMPL(a_fallback, out_valid, out_data.used_fallback == !$past(in_known, LAT))

endmodule
